// File: rtl/rotated_2bpp_framebuffer_pixel_writer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotated 2bpp frame store writer
// Clocked assertion helpers with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ROTATED_2BPP_FRAMEBUFFER_PIXEL_WRITER_CORE_MACROS_SVH
`define ROTATED_2BPP_FRAMEBUFFER_PIXEL_WRITER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RFBW_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("rfbw assertion failed");

// Implication with the consequent in the following cycle.
`define RFBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfbw assertion failed");

`endif

// File: rtl/rfbw_pkg.sv
// ----------------------------------------------------------------------------
// rfbw_pkg
// Shared constants, codes and types of the rotated 2bpp frame store writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfbw_pkg;

	localparam int DISP_WIDTH  = 64;
	localparam int RAW_ROWS    = 8;
	localparam int STORE_BYTES = 2 * DISP_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int XW          = $clog2(DISP_WIDTH);
	localparam int COORD_W     = 16;
	localparam int BYTE_ADDR_W = 7;
	localparam int BYTE_W      = 8;

	localparam logic [BYTE_W-1:0] SLOT_MASK = 8'h03;
	localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

	localparam logic CMD_DRAW  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [1:0] {
		ST_WRITTEN = 2'd0,
		ST_DROPPED = 2'd1,
		ST_CLEARED = 2'd2
	} status_t;

	// Raw location of one pixel in the store.
	typedef struct packed {
		logic              on_screen;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        slot;
	} pix_loc_t;

endpackage

// File: rtl/rotated_2bpp_framebuffer_pixel_writer_core.sv
// An accepted command beat is registered in stage 1, then its result in the output register.
// Throughput: one command per cycle while the output is not stalled, draws and clears
// alike; the frame RAM read-modify-write closes with forwarding of the last write.
// Clear invalidates all entries at once through per-byte valid flags.
// Reset: asynchronous, active low; the store reads as zero and rotation is 0.
// ----------------------------------------------------------------------------
// rotated_2bpp_framebuffer_pixel_writer_core
// Packed 2bpp frame store with rotated pixel writes and whole-store clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotated_2bpp_framebuffer_pixel_writer_core import rfbw_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [1:0]                color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [BYTE_ADDR_W-1:0]    byte_addr,
	output logic [BYTE_W-1:0]         byte_value
);

	rot_t              rotation_q;
	pix_loc_t          loc;
	logic              in_acc;
	logic              adv;

	logic              valid_s1;
	logic              cmd_s1;
	pix_loc_t          loc_s1;
	logic [1:0]        color_s1;

	logic [BYTE_W-1:0] rdata;
	logic [STORE_BYTES-1:0] filled_q;
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic [BYTE_W-1:0] lw_data_q;

	logic [BYTE_W-1:0] old_byte;
	logic [BYTE_W-1:0] new_byte;
	logic [2:0]        shamt;
	logic              do_write;

	logic              out_valid_q;
	status_t           status_q;
	logic [BYTE_ADDR_W-1:0] byte_addr_q;
	logic [BYTE_W-1:0] byte_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_0;
		end else if (cfg_we) begin
			rotation_q <= rot_t'(cfg_wdata);
		end
	end

	rfbw_coord u_coord (
		.rotation (rotation_q),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.loc      (loc)
	);

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= cmd;
			loc_s1   <= loc;
			color_s1 <= color;
		end
	end

	rfbw_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (BYTE_W)
	) u_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (loc_s1.addr),
		.wdata (new_byte),
		.re    (in_acc),
		.raddr (loc.addr),
		.rdata (rdata)
	);

	// A write landing on the same edge as the read is not seen by the RAM,
	// so the last written byte is forwarded. Unfilled bytes read as zero.
	always_comb begin
		if (lw_valid_q && (lw_addr_q == loc_s1.addr)) begin
			old_byte = lw_data_q;
		end else if (filled_q[loc_s1.addr]) begin
			old_byte = rdata;
		end else begin
			old_byte = '0;
		end
		shamt    = {loc_s1.slot, 1'b0};
		new_byte = (old_byte & ((SLOT_MASK << shamt) ^ BYTE_MASK))
		         | (BYTE_W'(color_s1) << shamt);
		do_write = adv && (cmd_s1 == CMD_DRAW) && loc_s1.on_screen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q   <= '0;
			lw_valid_q <= 1'b0;
		end else if (adv && (cmd_s1 == CMD_CLEAR)) begin
			filled_q   <= '0;
			lw_valid_q <= 1'b0;
		end else if (do_write) begin
			filled_q[loc_s1.addr] <= 1'b1;
			lw_valid_q            <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			lw_addr_q <= loc_s1.addr;
			lw_data_q <= new_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd_s1 == CMD_CLEAR) begin
				status_q     <= ST_CLEARED;
				byte_addr_q  <= '0;
				byte_value_q <= '0;
			end else if (!loc_s1.on_screen) begin
				status_q     <= ST_DROPPED;
				byte_addr_q  <= '0;
				byte_value_q <= '0;
			end else begin
				status_q     <= ST_WRITTEN;
				byte_addr_q  <= BYTE_ADDR_W'(loc_s1.addr);
				byte_value_q <= new_byte;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign byte_addr  = byte_addr_q;
	assign byte_value = byte_value_q;

endmodule

// File: rtl/rfbw_ram.sv
// ----------------------------------------------------------------------------
// rfbw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfbw_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/rfbw_coord.sv
// ----------------------------------------------------------------------------
// rfbw_coord
// Screen clipping and rotation of a signed point onto a store byte and slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfbw_coord import rfbw_pkg::*; (
	input  rot_t                       rotation,
	input  logic signed [COORD_W-1:0]  pos_x,
	input  logic signed [COORD_W-1:0]  pos_y,
	output pix_loc_t                   loc
);

	logic [COORD_W-1:0] w_lim;
	logic [COORD_W-1:0] h_lim;
	logic               x_ok;
	logic               y_ok;
	logic [XW-1:0]      rx;
	logic [2:0]         ry;

	always_comb begin
		if (rotation[0]) begin
			w_lim = COORD_W'(RAW_ROWS);
			h_lim = COORD_W'(DISP_WIDTH);
		end else begin
			w_lim = COORD_W'(DISP_WIDTH);
			h_lim = COORD_W'(RAW_ROWS);
		end
		x_ok = !pos_x[COORD_W-1] && ($unsigned(pos_x) < w_lim);
		y_ok = !pos_y[COORD_W-1] && ($unsigned(pos_y) < h_lim);

		// Only the low bits matter once the point is known to be on screen.
		unique case (rotation)
			ROT_90: begin
				rx = XW'(DISP_WIDTH - 1) - pos_y[XW-1:0];
				ry = pos_x[2:0];
			end
			ROT_180: begin
				rx = XW'(DISP_WIDTH - 1) - pos_x[XW-1:0];
				ry = ~pos_y[2:0];
			end
			ROT_270: begin
				rx = pos_y[XW-1:0];
				ry = ~pos_x[2:0];
			end
			default: begin
				rx = pos_x[XW-1:0];
				ry = pos_y[2:0];
			end
		endcase

		loc.on_screen = x_ok && y_ok;
		loc.addr      = ADDR_W'(rx) + (ry[2] ? ADDR_W'(DISP_WIDTH) : ADDR_W'(0));
		loc.slot      = ry[1:0];
	end

endmodule

// File: rtl/rfbw_checker.sv
// ----------------------------------------------------------------------------
// rfbw_checker
// Port-level checks of the frame store writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rotated_2bpp_framebuffer_pixel_writer_core_macros.svh"

module rfbw_checker import rfbw_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [1:0]             status,
	input logic [BYTE_ADDR_W-1:0] byte_addr,
	input logic [BYTE_W-1:0]      byte_value
);

	// A stalled result beat keeps its payload.
	`RFBW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(byte_addr) && $stable(byte_value))

	// Every accepted command is followed by a valid result beat.
	`RFBW_ASSERT(a_in_to_out, clk, arst_n, (in_valid && in_ready) |-> ##2 out_valid)

	// Dropped and cleared results report no byte.
	`RFBW_ASSERT(a_no_byte, clk, arst_n, (out_valid && (status != ST_WRITTEN)) |-> ((byte_addr == '0) && (byte_value == '0)))

	// Only the three defined status codes appear.
	`RFBW_ASSERT(a_status_code, clk, arst_n, out_valid |-> (status <= ST_CLEARED))

endmodule

bind rotated_2bpp_framebuffer_pixel_writer_core rfbw_checker u_rfbw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.byte_addr  (byte_addr),
	.byte_value (byte_value)
);
